[rtl/des_pkg.sv]
// Shared widths, constants and types for the diagonal equilibration scaler.
package des_pkg;

	localparam int DataW  = 32;
	localparam int IdxW   = 16;
	localparam int ScaleW = 24;
	localparam int CondW  = 17;
	localparam int OutW   = 112;

	localparam int MaxOrder = 65536;

	localparam int NumW  = 64;
	localparam int DivW  = 31;
	localparam int QuoW  = 49;
	localparam int StepW = 6;
	localparam logic [StepW-1:0] StepsScale = 6'd49;
	localparam logic [StepW-1:0] StepsCond  = 6'd63;

	localparam int RadW    = 50;
	localparam int RootW   = 25;
	localparam int RemW    = 26;
	localparam int SqStepW = 5;
	localparam logic [SqStepW-1:0] SqSteps = 5'd25;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_SQRT,
		ST_FDIV,
		ST_FSQRT,
		ST_EMIT
	} st_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

endpackage

[rtl/des_div.sv]
// Restoring divider that produces one quotient bit per cycle.
module des_div import des_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [NumW-1:0]      numerator,
	input  logic [DivW-1:0]      divisor,
	input  logic [StepW-1:0]     steps,
	output logic [QuoW-1:0]      quotient,
	output unit_stat_t           stat
);

	logic [NumW-1:0]  num_q;
	logic [DivW-1:0]  rem_q;
	logic [DivW-1:0]  div_q;
	logic [QuoW-1:0]  quo_q;
	logic [StepW-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DivW:0]    shifted;
	logic [DivW:0]    diff;
	logic             ge;
	logic [DivW-1:0]  rem_nx;

	always_comb begin
		shifted = {rem_q, num_q[NumW-1]};
		diff    = shifted - {1'b0, div_q};
		ge      = shifted >= {1'b0, div_q};
		rem_nx  = ge ? diff[DivW-1:0] : shifted[DivW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - StepW'(1);
				if (cnt_q == StepW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= numerator;
			div_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NumW-2:0], 1'b0};
			rem_q <= rem_nx;
			quo_q <= {quo_q[QuoW-2:0], ge};
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

[rtl/des_isqrt.sv]
// Digit-by-digit integer square root that produces one root bit per cycle.
module des_isqrt import des_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [RadW-1:0]  radicand,
	output logic [RootW-1:0] root,
	output unit_stat_t       stat
);

	logic [RadW-1:0]    rad_q;
	logic [RemW-1:0]    rem_q;
	logic [RootW-1:0]   root_q;
	logic [SqStepW-1:0] cnt_q;
	logic               busy_q;
	logic               done_q;

	logic [RemW+1:0]    shifted;
	logic [RemW+1:0]    trial;
	logic [RemW+1:0]    diff;
	logic               ge;
	logic [RemW-1:0]    rem_nx;

	always_comb begin
		shifted = {rem_q, rad_q[RadW-1 -: 2]};
		trial   = {1'b0, root_q, 2'b01};
		diff    = shifted - trial;
		ge      = shifted >= trial;
		rem_nx  = ge ? diff[RemW-1:0] : shifted[RemW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= SqSteps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - SqStepW'(1);
				if (cnt_q == SqStepW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[RadW-3:0], 2'b00};
			rem_q  <= rem_nx;
			root_q <= {root_q[RootW-2:0], ge};
		end
	end

	assign root      = root_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

[rtl/diagonal_equilibration_scaler_top.sv]
// A non-positive element goes PREP to EMIT; a positive one first runs the scale division and root.
// A final item whose elements are all positive also runs the ratio division and root before EMIT.
// One item is in work at a time; the next is accepted the cycle after the result is registered.
// The bit-serial divider (one quotient bit per cycle) and square root (one root bit) do the arithmetic.
// The result register lets the next item start while a result waits on the output.
// Asynchronous active-low reset clears the sequencer, the running statistics and the output valid.
module diagonal_equilibration_scaler_top import des_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [DataW-1:0] s_axis_tdata,  // diag_value[31:0]
	input  logic             s_axis_tlast,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// scale_factor[23:0], element_index[39:24], largest_diag[71:40], cond_ratio[88:72],
	// status[89], first_bad_index[105:90], zero fill[111:106]
	output logic [OutW-1:0]  m_axis_tdata,
	output logic             m_axis_tlast
);

	st_t state_q, state_nx;

	logic signed [DataW-1:0] d_q, min_q, max_q, d_in;
	logic                    fin_q;
	logic [IdxW-1:0]         idx_q, cnt_q, badpos_q;
	logic                    bad_q;
	logic [ScaleW-1:0]       scale_q;
	logic [CondW-1:0]        cond_q;
	logic                    m_valid_q, m_last_q;
	logic [OutW-1:0]         m_data_q;

	logic accept, d_pos, want_final, out_free;
	logic div_start, div_cond, sq_start, scale_ld, cond_ld, emit;

	logic [NumW-1:0]  div_num;
	logic [DivW-1:0]  div_den;
	logic [StepW-1:0] div_steps;
	logic [QuoW-1:0]  quotient;
	logic [RootW-1:0] root;
	unit_stat_t       div_stat, sq_stat;

	logic [DataW-1:0] o_largest;
	logic [CondW-1:0] o_cond;
	logic             o_status;
	logic [IdxW-1:0]  o_badidx;

	assign d_in       = signed'(s_axis_tdata);
	assign accept     = s_axis_tvalid & s_axis_tready;
	assign d_pos      = !d_q[DataW-1] && (d_q != '0);
	assign want_final = fin_q & !bad_q;
	assign out_free   = !m_valid_q | m_axis_tready;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) state_nx = ST_PREP;
			end
			ST_PREP: begin
				if (d_pos) state_nx = ST_DIV;
				else if (want_final) state_nx = ST_FDIV;
				else state_nx = ST_EMIT;
			end
			ST_DIV: begin
				if (div_stat.done) state_nx = ST_SQRT;
			end
			ST_SQRT: begin
				if (sq_stat.done) state_nx = want_final ? ST_FDIV : ST_EMIT;
			end
			ST_FDIV: begin
				if (div_stat.done) state_nx = ST_FSQRT;
			end
			ST_FSQRT: begin
				if (sq_stat.done) state_nx = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		div_start     = 1'b0;
		div_cond      = 1'b0;
		sq_start      = 1'b0;
		scale_ld      = 1'b0;
		cond_ld       = 1'b0;
		emit          = 1'b0;
		unique case (state_q)
			ST_IDLE: s_axis_tready = 1'b1;
			ST_PREP: begin
				div_start = d_pos | want_final;
				div_cond  = !d_pos;
			end
			ST_DIV: sq_start = div_stat.done;
			ST_SQRT: begin
				scale_ld  = sq_stat.done;
				div_start = sq_stat.done & want_final;
				div_cond  = 1'b1;
			end
			ST_FDIV: sq_start = div_stat.done;
			ST_FSQRT: cond_ld = sq_stat.done;
			ST_EMIT: emit = out_free;
			default: ;
		endcase
	end

	always_comb begin
		if (div_cond) begin
			div_num   = {min_q[DivW-1:0], {(NumW-DivW){1'b0}}};
			div_den   = max_q[DivW-1:0];
			div_steps = StepsCond;
		end else begin
			div_num   = {1'b1, {(NumW-1){1'b0}}};
			div_den   = d_q[DivW-1:0];
			div_steps = StepsScale;
		end
	end

	des_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.numerator (div_num),
		.divisor   (div_den),
		.steps     (div_steps),
		.quotient  (quotient),
		.stat      (div_stat)
	);

	des_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand ({{(RadW-QuoW){1'b0}}, quotient}),
		.root     (root),
		.stat     (sq_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			min_q     <= {1'b0, {(DataW-1){1'b1}}};
			max_q     <= {1'b1, {(DataW-1){1'b0}}};
			bad_q     <= 1'b0;
			badpos_q  <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (accept) begin
				if (d_in < min_q) min_q <= d_in;
				if (d_in > max_q) max_q <= d_in;
				if ((d_in[DataW-1] || d_in == '0) && !bad_q) begin
					bad_q    <= 1'b1;
					badpos_q <= cnt_q;
				end
			end
			if (emit) begin
				if (fin_q) begin
					cnt_q    <= '0;
					min_q    <= {1'b0, {(DataW-1){1'b1}}};
					max_q    <= {1'b1, {(DataW-1){1'b0}}};
					bad_q    <= 1'b0;
					badpos_q <= '0;
				end else if (cnt_q == IdxW'(MaxOrder - 1)) begin
					cnt_q <= '0;
				end else begin
					cnt_q <= cnt_q + IdxW'(1);
				end
			end
			if (emit) m_valid_q <= 1'b1;
			else if (m_axis_tready) m_valid_q <= 1'b0;
		end
	end

	always_comb begin
		o_largest = fin_q ? max_q : '0;
		o_cond    = fin_q ? cond_q : '0;
		o_status  = fin_q & bad_q;
		o_badidx  = (fin_q && bad_q) ? badpos_q : '0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			d_q     <= d_in;
			fin_q   <= s_axis_tlast;
			idx_q   <= cnt_q;
			scale_q <= '0;
			cond_q  <= '0;
		end
		if (scale_ld) scale_q <= root[RootW-1] ? {ScaleW{1'b1}} : root[ScaleW-1:0];
		if (cond_ld) cond_q <= root[CondW-1:0];
		if (emit) begin
			m_data_q <= {6'b0, o_badidx, o_status, o_cond, o_largest, idx_q, scale_q};
			m_last_q <= fin_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tlast  = m_last_q;

endmodule

[rtl/des_chk.sv]
// Port-level checker for the diagonal equilibration scaler and its bind.
module des_chk import des_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             s_axis_tvalid,
	input logic             s_axis_tready,
	input logic [DataW-1:0] s_axis_tdata,
	input logic             s_axis_tlast,
	input logic             m_axis_tvalid,
	input logic             m_axis_tready,
	input logic [OutW-1:0]  m_axis_tdata,
	input logic             m_axis_tlast
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("Output item changed while stalled.");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("Input accepted while an item is in work.");

	a_nonfinal_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[OutW-1:40] == '0)
		else $error("Summary fields set on a non-final item.");

	a_fail_cond: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[89] |-> m_axis_tdata[88:72] == '0)
		else $error("Ratio reported together with failure status.");

	a_success_idx: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[89] |-> m_axis_tdata[105:90] == '0)
		else $error("Bad index reported together with success status.");

endmodule

bind diagonal_equilibration_scaler_top des_chk u_des_chk (.*);
